// ===== design/lfs_pkg.sv =====
// Shared types and constants for the line follower steering block.
package lfs_pkg;

    localparam int SPEED_W = 7;
    localparam int GAIN_W  = 8;
    localparam int TICK_W  = 10;
    localparam int OUT_W   = 8;
    localparam int ERR_W   = 4;
    localparam int SENS_W  = 5;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 10;

    localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST   = 7'd30;
    localparam logic [GAIN_W-1:0]  STEER_GAIN_RST     = 8'd16;
    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST    = 7'd40;
    localparam logic [TICK_W-1:0]  STRAIGHT_TICKS_RST = 10'd20;
    localparam logic [TICK_W-1:0]  TURN_TICKS_RST     = 10'd40;
    localparam logic [SPEED_W-1:0] FAST_SPEED_RST     = 7'd30;
    localparam logic [SPEED_W-1:0] REVERSE_SPEED_RST  = 7'd20;

    typedef enum logic [CIDX_W-1:0] {
        CFG_CRUISE_SPEED   = 3'd0,
        CFG_STEER_GAIN     = 3'd1,
        CFG_SPEED_LIMIT    = 3'd2,
        CFG_STRAIGHT_TICKS = 3'd3,
        CFG_TURN_TICKS     = 3'd4,
        CFG_FAST_SPEED     = 3'd5,
        CFG_REVERSE_SPEED  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_TRACK    = 3'b001,
        PH_STRAIGHT = 3'b010,
        PH_SPIN     = 3'b100
    } t_phase;

    typedef struct packed {
        logic [SPEED_W-1:0] cruise_speed;
        logic [GAIN_W-1:0]  steer_gain;
        logic [SPEED_W-1:0] speed_limit;
        logic [TICK_W-1:0]  straight_ticks;
        logic [TICK_W-1:0]  turn_ticks;
        logic [SPEED_W-1:0] fast_speed;
        logic [SPEED_W-1:0] reverse_speed;
    } t_cfg;

    typedef struct packed {
        logic                    corner;
        logic                    corner_left;
        logic                    none_dark;
        logic signed [ERR_W-1:0] err_new;
        logic [OUT_W-1:0]        left_speed;
        logic [OUT_W-1:0]        right_speed;
    } t_steer;

    typedef struct packed {
        logic [OUT_W-1:0] left_speed;
        logic [OUT_W-1:0] right_speed;
    } t_speeds;

endpackage

// ===== design/lfs_cfg_regs.sv =====
// Configuration register file for the steering block.
module lfs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [lfs_pkg::CIDX_W-1:0]    i_wr_index,
    input  logic [lfs_pkg::CDATA_W-1:0]   i_wr_data,
    output lfs_pkg::t_cfg                 o_cfg
);

    lfs_pkg::t_cfg r_cfg;
    lfs_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (lfs_pkg::t_cfg_idx'(i_wr_index))
                lfs_pkg::CFG_CRUISE_SPEED: begin
                    n_cfg.cruise_speed = i_wr_data[lfs_pkg::SPEED_W-1:0];
                end
                lfs_pkg::CFG_STEER_GAIN: begin
                    n_cfg.steer_gain = i_wr_data[lfs_pkg::GAIN_W-1:0];
                end
                lfs_pkg::CFG_SPEED_LIMIT: begin
                    n_cfg.speed_limit = i_wr_data[lfs_pkg::SPEED_W-1:0];
                end
                lfs_pkg::CFG_STRAIGHT_TICKS: begin
                    n_cfg.straight_ticks = i_wr_data[lfs_pkg::TICK_W-1:0];
                end
                lfs_pkg::CFG_TURN_TICKS: begin
                    n_cfg.turn_ticks = i_wr_data[lfs_pkg::TICK_W-1:0];
                end
                lfs_pkg::CFG_FAST_SPEED: begin
                    n_cfg.fast_speed = i_wr_data[lfs_pkg::SPEED_W-1:0];
                end
                lfs_pkg::CFG_REVERSE_SPEED: begin
                    n_cfg.reverse_speed = i_wr_data[lfs_pkg::SPEED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise_speed   <= lfs_pkg::CRUISE_SPEED_RST;
            r_cfg.steer_gain     <= lfs_pkg::STEER_GAIN_RST;
            r_cfg.speed_limit    <= lfs_pkg::SPEED_LIMIT_RST;
            r_cfg.straight_ticks <= lfs_pkg::STRAIGHT_TICKS_RST;
            r_cfg.turn_ticks     <= lfs_pkg::TURN_TICKS_RST;
            r_cfg.fast_speed     <= lfs_pkg::FAST_SPEED_RST;
            r_cfg.reverse_speed  <= lfs_pkg::REVERSE_SPEED_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/lfs_steer.sv =====
// Tracking datapath: corner detect, weighted line error, proportional wheel speeds.
module lfs_steer (
    input  logic [lfs_pkg::SENS_W-1:0]       i_line_sensors,
    input  logic signed [lfs_pkg::ERR_W-1:0] i_held_error,
    input  lfs_pkg::t_cfg                    i_cfg,
    output lfs_pkg::t_steer                  o_steer
);

    logic [lfs_pkg::SENS_W-1:0]       dark;
    logic signed [lfs_pkg::ERR_W-1:0] err_new;
    logic signed [lfs_pkg::ERR_W-1:0] err_use;
    logic signed [lfs_pkg::ERR_W-1:0] err_neg;
    logic [2:0]                       err_mag;
    logic [10:0]                      prod;
    logic signed [8:0]                corr;
    logic signed [8:0]                base_s;
    logic signed [8:0]                lim_s;
    logic signed [8:0]                left_raw;
    logic signed [8:0]                right_raw;

    function automatic logic [lfs_pkg::OUT_W-1:0] clamp_mag(
        input logic signed [8:0] v,
        input logic signed [8:0] lim
    );
        logic signed [8:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end
        return r[lfs_pkg::OUT_W-1:0];
    endfunction

    always_comb begin
        dark    = ~i_line_sensors;
        err_new = (dark[4] ? 4'sd4 : 4'sd0) + (dark[3] ? 4'sd2 : 4'sd0)
                - (dark[1] ? 4'sd2 : 4'sd0) - (dark[0] ? 4'sd4 : 4'sd0);
        err_use = (dark == '0) ? i_held_error : err_new;
        err_neg = -err_use;
        err_mag = err_use[lfs_pkg::ERR_W-1] ? err_neg[2:0] : err_use[2:0];
        prod    = 11'(err_mag) * 11'(i_cfg.steer_gain);
        corr    = err_use[lfs_pkg::ERR_W-1] ? -$signed({2'b00, prod[10:4]})
                                            : $signed({2'b00, prod[10:4]});
        base_s    = $signed({2'b00, i_cfg.cruise_speed});
        lim_s     = $signed({2'b00, i_cfg.speed_limit});
        left_raw  = base_s + corr;
        right_raw = base_s - corr;

        o_steer.corner_left = dark[0] & dark[1];
        o_steer.corner      = (dark[0] & dark[1]) | (dark[3] & dark[4]);
        o_steer.none_dark   = (dark == '0);
        o_steer.err_new     = err_new;
        o_steer.left_speed  = clamp_mag(left_raw, lim_s);
        o_steer.right_speed = clamp_mag(right_raw, lim_s);
    end

endmodule

// ===== design/lfs_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
module lfs_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lfs_pkg::t_speeds i_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output lfs_pkg::t_speeds o_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    lfs_pkg::t_speeds r_out;
    lfs_pkg::t_speeds r_skid;
    logic             pop;

    assign pop     = r_out_valid & i_ready;
    assign o_space = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_out_valid) begin
            r_out_valid  <= r_skid_valid | i_push;
            r_skid_valid <= r_skid_valid & i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : i_data;
            if (i_push) begin
                r_skid <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat held without an output beat");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !pop) |-> !i_push)
        else $error("push into a full result buffer");

endmodule

// ===== design/line_follow_steering_fsm_unit.sv =====
// Line follower steering controller top level: phase sequencer and result path.
// The two-entry result buffer registers each result beat and decouples output stalls.
// Throughput: one input beat per cycle while the buffer's skid register is empty.
// A tracking-phase corner beat produces no result; every other beat produces exactly one.
// Reset (i_rst_n low, synchronous): tracking phase, countdown and held error cleared,
// configuration registers to defaults, result buffer emptied.
module line_follow_steering_fsm_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lfs_pkg::CIDX_W-1:0]          i_cfg_index,
    input  logic [lfs_pkg::CDATA_W-1:0]         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lfs_pkg::SENS_W-1:0]          i_line_sensors,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [lfs_pkg::OUT_W-1:0]    o_left_speed,
    output logic signed [lfs_pkg::OUT_W-1:0]    o_right_speed
);

    lfs_pkg::t_cfg   cfg;
    lfs_pkg::t_steer steer;
    lfs_pkg::t_speeds push_data;
    lfs_pkg::t_speeds out_data;

    lfs_pkg::t_phase                  r_phase, n_phase;
    logic [lfs_pkg::TICK_W-1:0]       r_countdown, n_countdown;
    logic                             r_turn_left, n_turn_left;
    logic signed [lfs_pkg::ERR_W-1:0] r_held_error, n_held_error;

    logic accept;
    logic push;
    logic cnt_last;
    logic buf_space;
    logic [lfs_pkg::OUT_W-1:0] fast_w;
    logic [lfs_pkg::OUT_W-1:0] rev_neg;

    assign o_cfg_ready = 1'b1;

    lfs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    lfs_steer u_steer (
        .i_line_sensors (i_line_sensors),
        .i_held_error   (r_held_error),
        .i_cfg          (cfg),
        .o_steer        (steer)
    );

    assign o_ready  = buf_space;
    assign accept   = i_valid & o_ready;
    assign cnt_last = (r_countdown[lfs_pkg::TICK_W-1:1] == '0);
    assign fast_w   = {1'b0, cfg.fast_speed};
    assign rev_neg  = lfs_pkg::OUT_W'(0) - {1'b0, cfg.reverse_speed};

    always_comb begin
        n_phase      = r_phase;
        n_countdown  = r_countdown;
        n_turn_left  = r_turn_left;
        n_held_error = r_held_error;
        push         = 1'b0;
        push_data.left_speed  = fast_w;
        push_data.right_speed = fast_w;
        if (accept) begin
            unique case (r_phase)
                lfs_pkg::PH_STRAIGHT: begin
                    push = 1'b1;
                    if (cnt_last) begin
                        n_phase     = lfs_pkg::PH_SPIN;
                        n_countdown = cfg.turn_ticks;
                    end else begin
                        n_countdown = r_countdown - 1'b1;
                    end
                end
                lfs_pkg::PH_SPIN: begin
                    push = 1'b1;
                    if (r_turn_left) begin
                        push_data.left_speed = rev_neg;
                    end else begin
                        push_data.right_speed = rev_neg;
                    end
                    if (cnt_last) begin
                        n_phase      = lfs_pkg::PH_TRACK;
                        n_countdown  = '0;
                        n_held_error = '0;
                    end else begin
                        n_countdown = r_countdown - 1'b1;
                    end
                end
                default: begin
                    if (steer.corner) begin
                        n_turn_left = steer.corner_left;
                        n_phase     = lfs_pkg::PH_STRAIGHT;
                        n_countdown = cfg.straight_ticks;
                    end else begin
                        push = 1'b1;
                        push_data.left_speed  = steer.left_speed;
                        push_data.right_speed = steer.right_speed;
                        if (!steer.none_dark) begin
                            n_held_error = steer.err_new;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lfs_pkg::PH_TRACK;
            r_countdown  <= '0;
            r_turn_left  <= 1'b0;
            r_held_error <= '0;
        end else begin
            r_phase      <= n_phase;
            r_countdown  <= n_countdown;
            r_turn_left  <= n_turn_left;
            r_held_error <= n_held_error;
        end
    end

    lfs_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_space (buf_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_left_speed  = out_data.left_speed;
    assign o_right_speed = out_data.right_speed;

    a_corner_to_straight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == lfs_pkg::PH_TRACK && steer.corner)
        |=> (r_phase == lfs_pkg::PH_STRAIGHT && r_countdown == $past(cfg.straight_ticks)))
        else $error("corner did not start the straight phase");

    a_straight_to_spin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == lfs_pkg::PH_STRAIGHT && cnt_last)
        |=> (r_phase == lfs_pkg::PH_SPIN && r_countdown == $past(cfg.turn_ticks)))
        else $error("straight phase did not hand over to spin");

    a_spin_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == lfs_pkg::PH_SPIN && cnt_last)
        |=> (r_phase == lfs_pkg::PH_TRACK && r_held_error == '0))
        else $error("spin end did not return to tracking with cleared error");

    a_held_error_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_error <= 4'sd4) && (r_held_error >= -4'sd4))
        else $error("held error out of range");

endmodule
